>>> sv/sitbd_pkg.sv
`default_nettype none

package sitbd_pkg;

  // configuration register file
  localparam int CFG_WORDS   = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int CHAR_W      = 8;

  // quotient bits settled per divider cycle
  localparam int BITS_PER_STEP = 4;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic push;
    logic pop;
    logic out_sign;
    logic out_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic scan_bad;
    logic radix_ok;
    logic div_last;
    logic quo_zero;
    logic neg;
    logic sp_zero;
  } dp_status_t;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9)) ||
           ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
           ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z));
  endfunction

endpackage

`default_nettype wire

>>> sv/sitbd_ram.sv
`default_nettype none

module sitbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/sitbd_datapath.sv
`default_nettype none

module sitbd_datapath #(
  parameter int VALUE_BITS     = 32,
  parameter int ALPHABET_SLOTS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [sitbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [sitbd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     in_data,
  input  wire sitbd_pkg::dp_cmd_t                  cmd,
  output sitbd_pkg::dp_status_t                    status,
  output logic      [sitbd_pkg::CHAR_W-1:0]        out_char,
  output logic                                     out_last
);

  localparam int SLOT_W = $clog2(ALPHABET_SLOTS);
  localparam int IDX_W  = $clog2(ALPHABET_SLOTS + 1);
  localparam int MAG_W  = ((VALUE_BITS + sitbd_pkg::BITS_PER_STEP - 1) /
                           sitbd_pkg::BITS_PER_STEP) * sitbd_pkg::BITS_PER_STEP;
  localparam int STEPS  = MAG_W / sitbd_pkg::BITS_PER_STEP;
  localparam int CNT_W  = $clog2(STEPS);
  localparam int SP_W   = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W = $clog2(VALUE_BITS);

  logic [sitbd_pkg::CFG_DATA_W-1:0] cfg_words [sitbd_pkg::CFG_WORDS];
  logic [sitbd_pkg::CHAR_W-1:0]     slot_byte [ALPHABET_SLOTS];

  logic                         neg;
  logic [MAG_W-1:0]             dvd;
  logic [IDX_W-1:0]             rem;
  logic [IDX_W-1:0]             scan_idx;
  logic [CNT_W-1:0]             cnt;
  logic [SP_W-1:0]              sp;

  logic [VALUE_BITS-1:0]        v_in;
  logic [VALUE_BITS-1:0]        v_mag;
  logic [SLOT_W-1:0]            sel_addr;
  logic [sitbd_pkg::CHAR_W-1:0] cur_byte;
  logic                         dup;
  logic [MAG_W-1:0]             dvd_next;
  logic [IDX_W-1:0]             rem_next;
  logic [SP_W-1:0]              sp_dec;
  logic [sitbd_pkg::CHAR_W-1:0] ram_rdata;

  // alphabet registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < sitbd_pkg::CFG_WORDS; w++) begin
        cfg_words[w] <= '0;
      end
    end else if (cfg_we) begin
      cfg_words[cfg_index] <= cfg_data;
    end
  end

  for (genvar g = 0; g < ALPHABET_SLOTS; g++) begin : g_slot
    assign slot_byte[g] = cfg_words[g / 8][(g % 8) * 8 +: 8];
  end

  // one shared character read: scan position, or digit value when pushing
  assign sel_addr = cmd.push ? rem[SLOT_W-1:0] : scan_idx[SLOT_W-1:0];
  assign cur_byte = slot_byte[sel_addr];

  // compare against every earlier character in parallel
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < ALPHABET_SLOTS; j++) begin
      if ((IDX_W'(j) < scan_idx) && (slot_byte[j] == cur_byte)) begin
        dup = 1'b1;
      end
    end
  end

  assign v_in  = in_data[VALUE_BITS-1:0];
  assign v_mag = v_in[VALUE_BITS-1] ? (~v_in + VALUE_BITS'(1)) : v_in;

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [IDX_W:0]   trial;
    logic [IDX_W-1:0] t_rem;
    logic [MAG_W-1:0] t_dvd;
    t_rem = rem;
    t_dvd = dvd;
    trial = '0;
    for (int k = 0; k < sitbd_pkg::BITS_PER_STEP; k++) begin
      trial = {t_rem, t_dvd[MAG_W-1]};
      t_dvd = {t_dvd[MAG_W-2:0], 1'b0};
      if (trial >= {1'b0, scan_idx}) begin
        trial    = trial - {1'b0, scan_idx};
        t_dvd[0] = 1'b1;
      end
      t_rem = trial[IDX_W-1:0];
    end
    rem_next = t_rem;
    dvd_next = t_dvd;
  end

  assign sp_dec = sp - SP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cnt      <= '0;
      sp       <= '0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmd.div_start) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.load) begin
        sp <= '0;
      end else if (cmd.push) begin
        sp <= sp + SP_W'(1);
      end else if (cmd.pop) begin
        sp <= sp_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= v_in[VALUE_BITS-1];
      dvd <= MAG_W'(v_mag);
    end else if (cmd.div_step) begin
      dvd <= dvd_next;
    end
    if (cmd.div_start) begin
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
    end
    if (cmd.out_sign) begin
      out_char <= sitbd_pkg::CHAR_MINUS;
      out_last <= 1'b0;
    end else if (cmd.out_digit) begin
      out_char <= ram_rdata;
      out_last <= (sp == '0);
    end
  end

  // digit stack, least significant digit pushed first
  sitbd_ram #(
    .WIDTH (sitbd_pkg::CHAR_W),
    .DEPTH (VALUE_BITS)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (sp[ADDR_W-1:0]),
    .wdata (cur_byte),
    .raddr (sp_dec[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign status.scan_end = (scan_idx == IDX_W'(ALPHABET_SLOTS)) ||
                           (cur_byte == sitbd_pkg::CHAR_NUL);
  assign status.scan_bad = !status.scan_end &&
                           (!sitbd_pkg::is_alnum(cur_byte) || dup);
  assign status.radix_ok = (scan_idx >= IDX_W'(2));
  assign status.div_last = (cnt == CNT_W'(STEPS - 1));
  assign status.quo_zero = (dvd == '0);
  assign status.neg      = neg;
  assign status.sp_zero  = (sp == '0);

endmodule

`default_nettype wire

>>> sv/sitbd_ctrl.sv
`default_nettype none

module sitbd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire sitbd_pkg::dp_status_t status,
  output sitbd_pkg::dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_PUSH,
    S_SIGN,
    S_READ,
    S_LOAD,
    S_SEND
  } state_t;

  state_t state;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SEND);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.scan_step = !status.scan_end && !status.scan_bad;
        cmd.div_start = status.scan_end && status.radix_ok;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_PUSH: begin
        cmd.push      = 1'b1;
        cmd.div_start = !status.quo_zero;
      end
      S_SIGN: begin
        cmd.out_sign = 1'b1;
      end
      S_READ: begin
        cmd.pop = 1'b1;
      end
      S_LOAD: begin
        cmd.out_digit = 1'b1;
      end
      S_SEND: begin
        cmd = '0;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          priority if (status.scan_bad) begin
            state <= S_IDLE;
          end else if (status.scan_end) begin
            state <= status.radix_ok ? S_DIV : S_IDLE;
          end
        end
        S_DIV: begin
          if (status.div_last) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (status.quo_zero) begin
            state <= status.neg ? S_SIGN : S_READ;
          end else begin
            state <= S_DIV;
          end
        end
        S_SIGN: begin
          state <= S_SEND;
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (out_ready) begin
            state <= status.sp_zero ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/signed_int_to_base_digits.sv
// Converts a signed two's complement value into its text in a radix given
// by a programmable digit alphabet, one character per output item. The
// alphabet sits in eight 64-bit registers, byte 0 of register 0 first, and
// ends at the first zero byte or after ALPHABET_SLOTS characters; its length
// is the radix. It is accepted only with at least two characters, all of
// them letters or decimal digits, none repeated; otherwise an input item
// produces no output at all. A negative value gives '-' first, then the
// digits of its magnitude (most negative value included) most significant
// first, with tlast on the final character. Zero gives alphabet character 0.
// One item is worked on at a time. It is accepted, then the alphabet check
// walks one character a cycle, then the divider, which settles four quotient
// bits a cycle, works out each digit, least significant first, and the digit
// stack hands the characters out most significant first (a minus sign is sent
// without it), each waiting on m_tready. Write the alphabet registers only
// while no item is in progress.

`default_nettype none

module signed_int_to_base_digits #(
  parameter int VALUE_BITS     = 32,
  parameter int ALPHABET_SLOTS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [sitbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sitbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,   // value (signed)
  // output stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [sitbd_pkg::CHAR_W-1:0]      m_tdata,   // text_char
  output logic                                   m_tlast    // last_char
);

  sitbd_pkg::dp_cmd_t    cmd;
  sitbd_pkg::dp_status_t status;

  // sequencer: alphabet check, digit loop, output handshake
  sitbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // alphabet registers, divider, digit stack and output register
  sitbd_datapath #(
    .VALUE_BITS     (VALUE_BITS),
    .ALPHABET_SLOTS (ALPHABET_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    VALUE_W         = 32;
  localparam int    DATA_W          = ((VALUE_W + 7) / 8) * 8;
  localparam int    SLOTS           = 64;
  localparam int    CHAR_W          = sitbd_pkg::CHAR_W;
  localparam int    CFG_WORDS       = sitbd_pkg::CFG_WORDS;
  localparam int    CFG_INDEX_W     = sitbd_pkg::CFG_INDEX_W;
  localparam int    CFG_DATA_W      = sitbd_pkg::CFG_DATA_W;
  // idle time after the last character before the alphabet may change; covers
  // a rejected item still walking a full alphabet and the longest binary text
  localparam int    SETTLE_CYCLES   = 600;
  localparam int    HOLD_OFF_CYCLES = 400;
  localparam int    MAX_REPORTS     = 10;
  localparam string ALNUM_POOL      =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

  // one expected character of the output text
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_item_t;

  // ways a random alphabet gets spoilt
  typedef enum int {
    FAULT_SHORT,
    FAULT_SYMBOL,
    FAULT_REPEAT
  } alphabet_fault_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata   = '0;   // value (signed)
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [CHAR_W-1:0]      m_tdata;          // text_char
  logic                   m_tlast;          // last_char

  // own copy of the alphabet registers, updated as they are written
  logic [CFG_DATA_W-1:0] alphabet_words [CFG_WORDS];
  // characters still owed by the block, oldest first
  text_item_t            expected_text [$];

  int fail_count    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;

  signed_int_to_base_digits #(
    .VALUE_BITS     (VALUE_W),
    .ALPHABET_SLOTS (SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // output side: a long hold-off when asked, otherwise random stalls
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  // compare every accepted character with the oldest one owed
  always @(posedge clk) begin : check_text
    text_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        note_failure($sformatf("unexpected char 0x%02h last %0b", m_tdata, m_tlast));
      end else begin
        want = expected_text.pop_front();
        if (m_tdata !== want.ch || m_tlast !== want.last) begin
          note_failure($sformatf("char expected 0x%02h last %0b, got 0x%02h last %0b",
                                 want.ch, want.last, m_tdata, m_tlast));
        end
      end
    end
  end

  function automatic bit letter_or_digit(input logic [CHAR_W-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // work out the text of one value under the current alphabet
  task automatic predict_text(input logic [VALUE_W-1:0] v);
    logic [CHAR_W-1:0] chars [$];
    logic [CHAR_W-1:0] order [$];
    logic [CHAR_W-1:0] c;
    bit                seen [256];
    bit                ok;
    logic [VALUE_W:0]  mag;
    int                radix;
    ok = 1'b1;
    for (int n = 0; n < SLOTS; n++) begin
      c = alphabet_words[n / 8][(n % 8) * 8 +: 8];
      if (c == sitbd_pkg::CHAR_NUL) break;
      if (!letter_or_digit(c) || seen[c]) ok = 1'b0;
      seen[c] = 1'b1;
      chars.push_back(c);
    end
    // rejected alphabet: nothing comes out
    if (!ok || chars.size() < 2) return;
    radix = chars.size();
    // magnitude one bit wider so the most negative value fits
    mag = v[VALUE_W-1] ? {1'b0, ~v} + 1'b1 : {1'b0, v};
    do begin
      order.push_front(chars[mag % radix]);
      mag = mag / radix;
    end while (mag != 0);
    if (v[VALUE_W-1]) expected_text.push_back(text_item_t'{sitbd_pkg::CHAR_MINUS, 1'b0});
    foreach (order[k]) begin
      expected_text.push_back(text_item_t'{order[k], k == order.size() - 1});
    end
  endtask

  // offer one value, with random gaps first; entered and left at a falling edge
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_W'(v);
    do @(posedge clk); while (!s_tready);
    predict_text(v);
    @(negedge clk);
  endtask

  // stop offering, let every owed character arrive, then let the block go idle
  task automatic wait_text_drained();
    s_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_words(input logic [CFG_DATA_W-1:0] words [CFG_WORDS]);
    for (int k = 0; k < CFG_WORDS; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_W'(k);
      cfg_data  <= words[k];
      alphabet_words[k] = words[k];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // byte 0 of word 0 is the first character; unused slots stay zero
  task automatic load_alphabet(input string s);
    logic [CFG_DATA_W-1:0] words [CFG_WORDS];
    for (int k = 0; k < CFG_WORDS; k++) words[k] = '0;
    for (int i = 0; i < s.len() && i < SLOTS; i++) begin
      words[i / 8][(i % 8) * 8 +: 8] = s[i];
    end
    load_words(words);
  endtask

  function automatic string shuffled_alphabet(input int radix);
    string pool;
    byte   tmp;
    int    j;
    pool = ALNUM_POOL;
    for (int i = pool.len() - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    return pool.substr(0, radix - 1);
  endfunction

  function automatic string spoilt_alphabet(input string s);
    alphabet_fault_t fault;
    byte             sym;
    fault = alphabet_fault_t'($urandom_range(0, 2));
    case (fault)
      FAULT_SHORT: begin
        s = s.substr(0, 0);
      end
      FAULT_SYMBOL: begin
        // any nonzero byte that is neither letter nor digit
        do sym = byte'($urandom_range(1, 255)); while (letter_or_digit(sym));
        s[$urandom_range(0, s.len() - 1)] = sym;
      end
      FAULT_REPEAT: begin
        s[s.len() - 1] = s[$urandom_range(0, s.len() - 2)];
      end
      default: ;
    endcase
    return s;
  endfunction

  // full range half the time, short texts and edge values for the rest
  function automatic logic [VALUE_W-1:0] random_value(input int radix);
    logic [VALUE_W-1:0] mag;
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: begin
        mag = $urandom_range(0, radix * radix * radix);
        return $urandom_range(0, 1) ? -mag : mag;
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       return {1'b1, {(VALUE_W-1){1'b0}}};
          1:       return {1'b0, {(VALUE_W-1){1'b1}}};
          2:       return '0;
          3:       return 1;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // all registers zero out of reset: empty alphabet, nothing comes out
  task automatic test_reset_alphabet();
    send_value(0);
    send_value(32'h8000_0000);
    wait_text_drained();
  endtask

  // too short, odd symbol, repeated char, all-ones bytes, no terminating zero
  task automatic test_rejected_alphabets();
    logic [CFG_DATA_W-1:0] ones [CFG_WORDS];
    load_alphabet("7");
    send_value(5);
    wait_text_drained();
    load_alphabet("01+");
    send_value(-3);
    wait_text_drained();
    load_alphabet("0120");
    send_value(100);
    wait_text_drained();
    for (int k = 0; k < CFG_WORDS; k++) ones[k] = '1;
    load_words(ones);
    send_value(1);
    wait_text_drained();
    // 64 characters fill every slot, so the pool must repeat
    load_alphabet({ALNUM_POOL, "01"});
    send_value(-1);
    wait_text_drained();
  endtask

  task automatic test_decimal_extremes();
    load_alphabet("0123456789");
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(10);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'h5555_5555);
    send_value(32'haaaa_aaaa);
    wait_text_drained();
  endtask

  // smallest and largest radix, and an alphabet in no natural order
  task automatic test_radix_extremes();
    load_alphabet("01");
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    send_value(-1);
    send_value(0);
    wait_text_drained();
    load_alphabet(ALNUM_POOL);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    send_value(61);
    send_value(-62);
    wait_text_drained();
    load_alphabet("zY9");
    send_value(8);
    send_value(-4);
    wait_text_drained();
  endtask

  // output held off while long binary texts pile up behind it
  task automatic test_output_hold_off();
    load_alphabet("01");
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (4) send_value($urandom);
    wait_text_drained();
  endtask

  // random alphabets, each followed by a burst of random values
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int target);
    int    favourite [5] = '{2, 10, 16, 36, 62};
    int    converted;
    int    radix;
    int    count;
    string abc;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    converted     = 0;
    while (converted < target) begin
      radix = ($urandom_range(0, 3) == 0) ? favourite[$urandom_range(0, 4)]
                                          : $urandom_range(2, 62);
      abc   = shuffled_alphabet(radix);
      count = $urandom_range(3, 10);
      // now and then a broken alphabet, whose items are simply swallowed
      if ($urandom_range(0, 7) == 0) begin
        abc   = spoilt_alphabet(abc);
        count = 2;
      end else begin
        converted += count;
      end
      load_alphabet(abc);
      repeat (count) send_value(random_value(radix));
      wait_text_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 46;
    test_reset_alphabet();
    test_rejected_alphabets();
    test_decimal_extremes();
    test_radix_extremes();
    test_output_hold_off();
    test_random_traffic(13, 46, 42);
    test_random_traffic(46, 13, 42);
    test_random_traffic(0, 0, 42);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
